>>> rtl/core/sshash_pkg.sv
// Package for the string signature hash block.
// Holds the shared types, constants and the rotate helper.
// No dependencies.
`timescale 1ns / 1ps

package sshash_pkg;

  // Messages of up to ShortLimit bytes take the raw path.
  localparam logic [3:0] ShortLimit = 4'd8;
  // The byte counter stops here, one past the short limit.
  localparam logic [3:0] LenSat     = 4'd9;
  // A word has this many bytes; the short path checks for one whole word.
  localparam logic [3:0] WordBytes  = 4'd4;
  // Last byte position inside a word.
  localparam logic [1:0] LastPos    = 2'd3;

  // One byte request as it leaves the input register.
  typedef struct packed {
    logic       go;    // request moves into the accumulator this cycle
    logic       last;  // final byte of the message
    logic [7:0] data;
  } byte_req_t;

  // Signature pair for one message.
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } sig_t;

  // Rotate left; a shift of zero leaves the word as it is.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] t;
    t = {v, v} << r;
    return t[63:32];
  endfunction

endpackage

>>> rtl/core/sshash_acc.sv
// Accumulator for the string signature hash: packs bytes into words,
// keeps the even/odd word sums and builds the signature on the last byte.
// Depends on sshash_pkg.
`timescale 1ns / 1ps

module sshash_acc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sshash_pkg::byte_req_t req_i,
  output sshash_pkg::sig_t      sig_o
);

  logic [23:0] partial_q, partial_d;
  logic [1:0]  biw_q, biw_d;
  logic [31:0] odd_q, odd_d;
  logic [31:0] even_q, even_d;
  logic [4:0]  wc_q, wc_d;
  logic [3:0]  len_q, len_d;

  logic [31:0] cur;
  logic        completes;
  logic [31:0] odd_add, even_add;
  logic [31:0] odd_f, even_f, tail;
  logic [4:0]  wc_inc, wc_f;

  // Merge the new byte into the word being built
  always_comb begin
    case (biw_q)
      2'd0:    cur = {24'd0, req_i.data};
      2'd1:    cur = {16'd0, req_i.data, partial_q[7:0]};
      2'd2:    cur = {8'd0, req_i.data, partial_q[15:0]};
      default: cur = {req_i.data, partial_q};
    endcase
  end

  assign completes = (biw_q == sshash_pkg::LastPos);
  assign odd_add   = odd_q + cur;
  assign even_add  = even_q + cur;
  assign wc_inc    = wc_q + 5'd1;

  // Sums as they stand once the final word, if whole, is folded in
  assign odd_f  = (completes && wc_q[0])  ? odd_add  : odd_q;
  assign even_f = (completes && !wc_q[0]) ? even_add : even_q;
  assign wc_f   = completes ? wc_inc : wc_q;
  assign tail   = completes ? 32'd0 : cur;

  // Signature: raw bytes for short messages, rotated sums plus the partial tail word otherwise
  always_comb begin
    if (len_q < sshash_pkg::ShortLimit) begin
      if (len_q < sshash_pkg::WordBytes) begin
        sig_o.first  = cur;
        sig_o.second = 32'd0;
      end else begin
        // the only whole word so far sits in the even sum
        sig_o.first  = even_q;
        sig_o.second = cur;
      end
    end else begin
      sig_o.first  = sshash_pkg::rotl32(odd_f, wc_f) + tail;
      sig_o.second = sshash_pkg::rotl32(even_f, wc_f) + tail;
    end
  end

  // Next state
  always_comb begin
    partial_d = partial_q;
    biw_d     = biw_q;
    odd_d     = odd_q;
    even_d    = even_q;
    wc_d      = wc_q;
    len_d     = len_q;
    if (req_i.go) begin
      if (req_i.last) begin
        partial_d = '0;
        biw_d     = '0;
        odd_d     = '0;
        even_d    = '0;
        wc_d      = '0;
        len_d     = '0;
      end else begin
        if (completes) begin
          if (wc_q[0]) begin
            odd_d = odd_add;
          end else begin
            even_d = even_add;
          end
          wc_d      = wc_inc;
          partial_d = '0;
          biw_d     = '0;
        end else begin
          partial_d = cur[23:0];
          biw_d     = biw_q + 2'd1;
        end
        if (len_q < sshash_pkg::LenSat) begin
          len_d = len_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      biw_q     <= '0;
      odd_q     <= '0;
      even_q    <= '0;
      wc_q      <= '0;
      len_q     <= '0;
    end else begin
      partial_q <= partial_d;
      biw_q     <= biw_d;
      odd_q     <= odd_d;
      even_q    <= even_d;
      wc_q      <= wc_d;
      len_q     <= len_d;
    end
  end

endmodule

>>> rtl/core/string_signature_hash64.sv
// Top level of the string signature hash: input register, accumulator
// and result register. Depends on sshash_pkg and sshash_acc.
`timescale 1ns / 1ps

// The block hashes one message byte per clock while the input is not
// stalled. A byte request is taken into an input register and folded
// into the word sums as it leaves that register; the signature pair of
// a message is caught in the result register as its last byte moves on.
// Each byte needs a single add per word sum, with the final rotate and
// tail add between the input and result registers. Input stall rises
// only when a last byte waits in the input register while the previous
// signature is still stalled at the output.
module string_signature_hash64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sign_first_o,
  output logic [31:0] sign_second_o
);

  logic       s1_valid_q, s1_valid_d;
  logic       s1_last_q;
  logic [7:0] s1_data_q;
  logic       s1_go;
  logic       in_take;

  logic              out_valid_q, out_valid_d;
  sshash_pkg::sig_t  out_q;
  sshash_pkg::sig_t  sig;
  sshash_pkg::byte_req_t req;

  // A last byte can only move on when the result slot frees up
  assign s1_go      = s1_valid_q && !(s1_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Word packing and sums
  assign req.go   = s1_go;
  assign req.last = s1_last_q;
  assign req.data = s1_data_q;

  sshash_acc u_acc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .sig_o (sig)
  );

  // Result register
  always_comb begin
    if (s1_go && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_q <= sig;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sign_first_o  = out_q.first;
  assign sign_second_o = out_q.second;

  // Input only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_last_q))
    else $error("input stalled without a held result");

  // A fresh result always comes from a last byte leaving the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a last byte");

  // A held result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_q))
    else $error("held result changed");

endmodule
